// ===== design/bt_pkg.sv =====
package bt_pkg;

  localparam int MAX_BLOCK_DEF = 9;
  localparam int DIGIT_W       = 4;
  localparam int KEY_DIGITS    = 9;
  localparam int KEY_W         = DIGIT_W * KEY_DIGITS;
  localparam int KEY_EXT_W     = DIGIT_W * 16;
  localparam int CFG_DATA_W    = KEY_W;

  localparam logic       MODE_ENCRYPT = 1'b0;
  localparam logic       MODE_DECRYPT = 1'b1;

  localparam logic             RST_MODE      = MODE_ENCRYPT;
  localparam logic [3:0]       RST_BLOCK_LEN = 4'd9;
  localparam logic [KEY_W-1:0] RST_KEY_ORDER = 36'h987654321;
  localparam logic [7:0]       RST_PAD_BYTE  = 8'hDA;

  typedef enum logic [1:0] {
    REG_MODE      = 2'd0,
    REG_BLOCK_LEN = 2'd1,
    REG_KEY_ORDER = 2'd2,
    REG_PAD_BYTE  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] key_order;
    logic [7:0]       pad_byte;
  } cfg_t;

  function automatic logic [DIGIT_W-1:0] key_digit(logic [KEY_W-1:0] key, int j);
    logic [KEY_EXT_W-1:0] ext;
    ext = KEY_EXT_W'(key);
    return ext[DIGIT_W*j +: DIGIT_W];
  endfunction

endpackage

// ===== design/bt_front.sv =====
module bt_front #(
  parameter int MAX_BLOCK = bt_pkg::MAX_BLOCK_DEF,
  parameter int CW        = $clog2(MAX_BLOCK + 1),
  parameter int DW        = 8 * MAX_BLOCK + CW + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_is_last,
  input  bt_pkg::cfg_t         cfg,
  input  logic [CW-1:0]        eff_len,
  output logic                 push,
  output logic [DW-1:0]        push_data,
  input  logic                 push_ready
);
  import bt_pkg::*;

  logic [MAX_BLOCK-1:0][7:0] blk_r, blk_nxt, merged;
  logic [CW-1:0]             fill_r, fill_nxt, fill_inc;
  logic [7:0]                byte_c;
  logic                      keep;
  logic                      accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    byte_c = in_data_byte;
    keep   = 1'b1;
    if (cfg.mode == MODE_ENCRYPT) begin
      if (byte_c inside {8'h20, [8'h09:8'h0D]}) begin
        keep = 1'b0;
      end else if (byte_c inside {[8'h61:8'h7A]}) begin
        byte_c = byte_c - 8'h20;
      end
    end
    fill_inc = CW'(fill_r + CW'(keep));
    merged   = blk_r;
    for (int i = 0; i < MAX_BLOCK; i++) begin
      if (keep && fill_r == CW'(i)) merged[i] = byte_c;
    end
    push      = accept && ((fill_inc >= eff_len) || in_is_last);
    push_data = {in_is_last, fill_inc, merged};
    blk_nxt   = accept ? merged : blk_r;
    fill_nxt  = fill_r;
    if (accept) fill_nxt = push ? '0 : fill_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

endmodule

// ===== design/bt_queue.sv =====
module bt_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  logic [DW-1:0] wr_data,
  output logic          rd_valid,
  input  logic          rd_pop,
  output logic [DW-1:0] rd_data
);
  import bt_pkg::*;

  logic [1:0][DW-1:0] mem_r;
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         count_r, count_nxt;
  logic               do_wr, do_rd;

  assign wr_ready = !count_r[1];
  assign rd_valid = count_r != 2'd0;
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) count_nxt = count_r + 2'd1;
    else if (do_rd && !do_wr) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_r <= !wr_ptr_r;
      if (do_rd) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

// ===== design/bt_back.sv =====
module bt_back #(
  parameter int MAX_BLOCK = bt_pkg::MAX_BLOCK_DEF,
  parameter int CW        = $clog2(MAX_BLOCK + 1),
  parameter int DW        = 8 * MAX_BLOCK + CW + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  logic [DW-1:0] q_data,
  output logic          q_pop,
  input  bt_pkg::cfg_t  cfg,
  input  logic [CW-1:0] eff_len,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_byte_valid,
  output logic          out_end_of_message
);
  import bt_pkg::*;

  logic                      q_last;
  logic [CW-1:0]             q_cnt;
  logic [MAX_BLOCK-1:0][7:0] q_bytes, blk, res;
  logic [CW-1:0]             n;
  logic [DIGIT_W-1:0]        d;

  logic [MAX_BLOCK-1:0][7:0] res_r;
  logic [CW-1:0]             n_r, k_r, k_nxt;
  logic                      last_r, busy_r, busy_nxt;
  logic                      final_beat, load;
  logic [7:0]                sel;

  assign q_last  = q_data[DW-1];
  assign q_cnt   = q_data[DW-2 -: CW];
  assign q_bytes = q_data[8*MAX_BLOCK-1:0];

  always_comb begin
    d = '0;
    for (int i = 0; i < MAX_BLOCK; i++) begin
      blk[i] = (CW'(i) < q_cnt) ? q_bytes[i] : cfg.pad_byte;
      res[i] = cfg.pad_byte;
    end
    if (cfg.mode == MODE_ENCRYPT) begin
      for (int k = 0; k < MAX_BLOCK; k++) begin
        d = key_digit(cfg.key_order, k);
        for (int i = 0; i < MAX_BLOCK; i++) begin
          if ({1'b0, d} == 5'(i + 1) && CW'(i) < eff_len) res[k] = blk[i];
        end
      end
    end else begin
      for (int j = 0; j < MAX_BLOCK; j++) begin
        d = key_digit(cfg.key_order, j);
        for (int k = 0; k < MAX_BLOCK; k++) begin
          if (CW'(j) < eff_len && {1'b0, d} == 5'(k + 1) && CW'(k) < eff_len) begin
            res[k] = blk[j];
          end
        end
      end
    end
    if (q_cnt == '0) begin
      n = '0;
    end else if (cfg.mode == MODE_DECRYPT && q_last) begin
      n = '0;
      for (int i = 0; i < MAX_BLOCK; i++) begin
        if (CW'(i) < eff_len && res[i] != cfg.pad_byte) n = CW'(i + 1);
      end
    end else begin
      n = eff_len;
    end
  end

  always_comb begin
    final_beat = (n_r == '0) || (CW'(k_r + CW'(1)) >= n_r);
    load       = q_valid && (!busy_r || (out_ready && final_beat));
    busy_nxt   = busy_r;
    k_nxt      = k_r;
    if (load) begin
      busy_nxt = 1'b1;
      k_nxt    = '0;
    end else if (busy_r && out_ready) begin
      if (final_beat) busy_nxt = 1'b0;
      else k_nxt = CW'(k_r + CW'(1));
    end
    sel = 8'd0;
    for (int i = 0; i < MAX_BLOCK; i++) begin
      if (k_r == CW'(i)) sel = res_r[i];
    end
  end

  assign q_pop              = load;
  assign out_valid          = busy_r;
  assign out_byte_valid     = n_r != '0;
  assign out_byte           = out_byte_valid ? sel : 8'd0;
  assign out_end_of_message = last_r && final_beat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= res;
      n_r    <= n;
      last_r <= q_last;
    end
  end

endmodule

// ===== design/block_transposition_cipher.sv =====
// Block transposition cipher over a byte stream.
// Input channel (in_valid/in_ready): one text byte per beat, in_is_last on
// the final byte of a message. Result channel (out_valid/out_ready): one
// transposed byte per beat; out_end_of_message on the last beat of a
// message, out_byte_valid low only on an empty end-of-message beat.
// Configuration: cfg_we writes register cfg_index (mode, block length, key
// digits, pad byte) with cfg_data; write only while the block is idle.
// A completed block is written into the queue, then into the back end's
// result register before its first byte leaves. Throughput: one byte per
// cycle on each side unless stalled; bytes leave from a registered, permuted
// block, and a two-entry block queue lets the front fill the next meanwhile.
// When the receiver stalls, the output beat holds and the front keeps
// taking bytes until the queue fills, then drops in_ready.
// Reset (synchronous, rst_n low) empties the queue and the partial block and
// restores encrypt mode, length 9, the identity key and pad byte 0xDA.
module block_transposition_cipher #(
  parameter int MAX_BLOCK = bt_pkg::MAX_BLOCK_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_is_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic                          out_byte_valid,
  output logic                          out_end_of_message,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [bt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bt_pkg::*;

  localparam int CW = $clog2(MAX_BLOCK + 1);
  localparam int DW = 8 * MAX_BLOCK + CW + 1;

  logic             mode_r;
  logic [3:0]       block_len_r;
  logic [KEY_W-1:0] key_order_r;
  logic [7:0]       pad_byte_r;
  cfg_t             cfg;
  logic [CW-1:0]    eff_len;

  logic             push, push_ready, q_valid, q_pop;
  logic [DW-1:0]    push_data, q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= RST_MODE;
      block_len_r <= RST_BLOCK_LEN;
      key_order_r <= RST_KEY_ORDER;
      pad_byte_r  <= RST_PAD_BYTE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:      mode_r      <= cfg_data[0];
        REG_BLOCK_LEN: block_len_r <= cfg_data[3:0];
        REG_KEY_ORDER: key_order_r <= cfg_data[KEY_W-1:0];
        REG_PAD_BYTE:  pad_byte_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.mode      = mode_r;
    cfg.key_order = key_order_r;
    cfg.pad_byte  = pad_byte_r;
    if (block_len_r == 4'd0) eff_len = CW'(1);
    else if ({1'b0, block_len_r} > 5'(MAX_BLOCK)) eff_len = CW'(MAX_BLOCK);
    else eff_len = CW'(block_len_r);
  end

  bt_front #(
    .MAX_BLOCK (MAX_BLOCK),
    .CW        (CW),
    .DW        (DW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_is_last   (in_is_last),
    .cfg          (cfg),
    .eff_len      (eff_len),
    .push         (push),
    .push_data    (push_data),
    .push_ready   (push_ready)
  );

  bt_queue #(
    .DW (DW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_data  (q_data)
  );

  bt_back #(
    .MAX_BLOCK (MAX_BLOCK),
    .CW        (CW),
    .DW        (DW)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_data             (q_data),
    .q_pop              (q_pop),
    .cfg                (cfg),
    .eff_len            (eff_len),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_byte_valid     (out_byte_valid),
    .out_end_of_message (out_end_of_message)
  );

endmodule
